// ----- hw/rtl/xbir_pkg.sv -----
// Shared constants, codes and types of the bounded-index random generator.
package xbir_pkg;

    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] STAR_MUL      = 64'h2545_F491_4F6C_DD1D;
    localparam logic [WORD_W-1:0] ZERO_FALLBACK = 64'hA5A5_A5A5_A5A5_A5A5;
    // splitmix64 finalizer applied to zero, i.e. the value 0 plus the golden gamma
    // 0x9E3779B97F4A7C15 mixed by 0xBF58476D1CE4E5B9 and 0x94D049BB133111EB.
    localparam logic [WORD_W-1:0] MIX_OF_ZERO   = 64'hE220_A839_7B1D_CDAF;
    // State that replaces an all-zero generator state before a draw.
    localparam logic [WORD_W-1:0] RESEED_VALUE  =
        (MIX_OF_ZERO != '0) ? MIX_OF_ZERO : ZERO_FALLBACK;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_RAW     = 2'd1,
        FUNC_BOUNDED = 2'd2,
        FUNC_NONE    = 2'd3
    } xbir_func_t;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } xbir_sts_t;

endpackage

// ----- hw/rtl/xbir_mul.sv -----
// Bit-serial multiplier of a 64-bit operand by the xorshift64* output constant.
module xbir_mul
    import xbir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] operand,
    output logic [WORD_W-1:0] product,
    output xbir_sts_t         sts
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] mcand_reg, mcand_next;
    logic [WORD_W-1:0] coef_reg, coef_next;
    logic [WORD_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        coef_next  = coef_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = operand;
            coef_next  = STAR_MUL;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            // One multiplier bit per cycle, low bit first.
            if (coef_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[WORD_W-2:0], 1'b0};
            coef_next  = {1'b0, coef_reg[WORD_W-1:1]};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        coef_reg  <= coef_next;
        acc_reg   <= acc_next;
    end

    assign product  = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ----- hw/rtl/xbir_rem.sv -----
// Bit-serial restoring remainder unit for a 64-bit dividend and divisor.
module xbir_rem
    import xbir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic [WORD_W-1:0] remainder,
    output xbir_sts_t         sts
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Bring in one dividend bit, subtract when the divisor fits.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = WORD_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

endmodule

// ----- hw/rtl/xorshift_bounded_index_rng.sv -----
// A seed load, the unused code or a size-zero error goes via FINISH to the output register; a
// raw draw runs the 64-step bit-serial multiply by the output constant; a bounded draw runs the
// limit remainder beside the first multiply, then a 64-step remainder, and each rejected raw
// value costs one more multiply. Throughput: one item at a time; a new request is accepted only
// once the previous result has been handed to the output register.
// Reset (rst_n low, asynchronous) zeroes the generator state and empties the output register.
module xorshift_bounded_index_rng
    import xbir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] seed_value, [127:64] range_size
    input  logic [1:0]   s_tuser,   // [1:0] func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [63:0] value
    output logic         m_tuser    // [0] size_error
);

    // Sequencer states. DRAW runs the multiplier, CHECK applies the rejection
    // test to a bounded draw and passes a raw one on, MOD reduces an accepted
    // value, FINISH hands the result to the output register once that register is free.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DRAW   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MOD    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] gen_reg, gen_next;
    logic              bounded_reg, bounded_next;
    logic [WORD_W-1:0] n_reg, n_next;
    logic [WORD_W-1:0] limit_reg, limit_next;
    logic [WORD_W-1:0] res_value_reg, res_value_next;
    logic              res_err_reg, res_err_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic              out_err_reg, out_err_next;

    logic              accept;
    xbir_func_t        func;
    logic [WORD_W-1:0] seed_value;
    logic [WORD_W-1:0] range_size;
    logic [WORD_W-1:0] stepped;
    logic              mul_start;
    logic [WORD_W-1:0] mul_product;
    xbir_sts_t         mul_sts;
    logic              rem_start;
    logic [WORD_W-1:0] rem_dividend;
    logic [WORD_W-1:0] rem_result;
    xbir_sts_t         rem_sts;

    // One xorshift64 step of the current state, with a zero state reseeded first.
    function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] cur);
        logic [WORD_W-1:0] s;
        s = (cur == '0) ? RESEED_VALUE : cur;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        return s;
    endfunction

    assign func       = xbir_func_t'(s_tuser);
    assign seed_value = s_tdata[63:0];
    assign range_size = s_tdata[127:64];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign stepped    = xs_step(gen_reg);

    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        bounded_next   = bounded_reg;
        n_next         = n_reg;
        limit_next     = limit_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        mul_start      = 1'b0;
        rem_start      = 1'b0;
        rem_dividend   = mul_product;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rem_dividend = ALL_ONES;
                if (accept)
                begin
                    res_value_next = '0;
                    res_err_next   = 1'b0;
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            gen_next   = seed_value;
                            state_next = ST_FINISH;
                        end
                        FUNC_RAW:
                        begin
                            gen_next     = stepped;
                            mul_start    = 1'b1;
                            bounded_next = 1'b0;
                            state_next   = ST_DRAW;
                        end
                        FUNC_BOUNDED:
                        begin
                            if (range_size == '0)
                            begin
                                res_err_next = 1'b1;
                                state_next   = ST_FINISH;
                            end
                            else
                            begin
                                // The limit remainder runs alongside the first multiply.
                                gen_next     = stepped;
                                mul_start    = 1'b1;
                                rem_start    = 1'b1;
                                bounded_next = 1'b1;
                                n_next       = range_size;
                                state_next   = ST_DRAW;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                if (rem_sts.done)
                begin
                    // floor(max/n)*n equals max minus (max mod n).
                    limit_next = ~rem_result;
                end
                if (mul_sts.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!bounded_reg)
                begin
                    res_value_next = mul_product;
                    state_next     = ST_FINISH;
                end
                else if (mul_product >= limit_reg)
                begin
                    gen_next   = stepped;
                    mul_start  = 1'b1;
                    state_next = ST_DRAW;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (rem_sts.done)
                begin
                    res_value_next = rem_result;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= '0;
            bounded_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            bounded_reg   <= bounded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        limit_reg     <= limit_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    xbir_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (gen_next),
        .product (mul_product),
        .sts     (mul_sts)
    );

    xbir_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   ((state_reg == ST_IDLE) ? range_size : n_reg),
        .remainder (rem_result),
        .sts       (rem_sts)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_err_reg;

    // The multiplier only runs while a draw is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.busy |-> state_reg == ST_DRAW)
        else $error("multiplier busy outside of a draw");

    // The remainder unit only runs for the limit or the final reduction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_sts.busy |-> (state_reg == ST_DRAW || state_reg == ST_MOD))
        else $error("remainder unit busy in an unexpected state");

    // A reduced index is always below the requested size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && rem_sts.done) |-> rem_result < n_reg)
        else $error("bounded index not below range size");

    // A pending result waits while the output register holds an untaken transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !m_tready)
            |=> (state_reg == ST_FINISH && out_valid_reg))
        else $error("result overwrote an untaken transfer");

endmodule
